// ===== rtl/core/rob_pkg.sv =====
package rob_pkg;

  localparam int DEPTH        = 16;
  localparam int SLOT_W       = $clog2(DEPTH);
  localparam int PAYLOAD_BITS = 64;
  localparam int SEQ_W        = 32;
  localparam int DATA_W       = 64;
  localparam int CNT_W        = 8;
  localparam int CFG_IDX_W    = 1;

  localparam logic [SEQ_W-1:0] RESET_FIRST_SEQ = '0;
  localparam logic [CNT_W-1:0] RESET_PRODUCERS = CNT_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SEQ      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PRODUCER_TOTAL = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    CMD_PUSH      = 2'd0,
    CMD_POP       = 2'd1,
    CMD_DONE      = 2'd2,
    CMD_INTERRUPT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_INTERRUPTED = 3'd2,
    ST_STALE       = 3'd3,
    ST_DUPLICATE   = 3'd4,
    ST_EMPTY       = 3'd5,
    ST_FINISHED    = 3'd6
  } status_t;

endpackage

// ===== rtl/core/in_order_reorder_buffer.sv =====
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | cmd, seq_in, data_in
// out     | output    | out_valid / out_ready  | status, seq_out, data_out
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one command per cycle while in_ready is high; out_valid rises when the middle stage moves into the output registers
// the slot ram is read once, on pop, and its registered data feeds the output stage
// valid bits, head and counters update at the accepting edge, so the next command sees them
// synchronous reset clears all valid bits and restores head and producer count
// a stalled output holds the middle stage; input stalls only once both stages are full
module in_order_reorder_buffer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         cmd,
  input  logic [rob_pkg::SEQ_W-1:0]          seq_in,
  input  logic [rob_pkg::DATA_W-1:0]         data_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         status,
  output logic [rob_pkg::SEQ_W-1:0]          seq_out,
  output logic [rob_pkg::DATA_W-1:0]         data_out,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rob_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rob_pkg::SEQ_W-1:0]          cfg_data
);
  import rob_pkg::*;

  logic [DEPTH-1:0]        slot_valid;
  logic [DEPTH-1:0]        slot_valid_next;
  logic [SEQ_W-1:0]        head_seq;
  logic [SEQ_W-1:0]        head_seq_next;
  logic [CNT_W-1:0]        producers_left;
  logic [CNT_W-1:0]        producers_left_next;
  logic                    interrupted;
  logic                    interrupted_next;

  logic                    p_valid;
  logic                    p_pop;
  status_t                 p_status;
  logic [SEQ_W-1:0]        p_seq;

  logic                    in_fire;
  logic                    cfg_fire;
  logic                    p_move;
  logic [SEQ_W-1:0]        push_diff;
  logic [SLOT_W-1:0]       push_slot;
  logic [SLOT_W-1:0]       head_slot;
  status_t                 res_status;
  logic                    res_pop;
  logic [SEQ_W-1:0]        res_seq;
  logic                    wr_en;
  logic                    rd_en;
  logic [PAYLOAD_BITS-1:0] rd_data;

  rob_ram #(
    .WIDTH(PAYLOAD_BITS),
    .DEPTH(DEPTH)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(push_slot),
    .wr_data(data_in[PAYLOAD_BITS-1:0]),
    .rd_en  (rd_en),
    .rd_addr(head_slot),
    .rd_data(rd_data)
  );

  assign cfg_ready = 1'b1;
  assign p_move    = p_valid && (!out_valid || out_ready);
  assign in_ready  = !p_valid || p_move;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign push_diff = seq_in - head_seq;
  assign push_slot = seq_in[SLOT_W-1:0];
  assign head_slot = head_seq[SLOT_W-1:0];

  always_comb begin
    slot_valid_next     = slot_valid;
    head_seq_next       = head_seq;
    producers_left_next = producers_left;
    interrupted_next    = interrupted;
    res_status          = ST_OK;
    res_pop             = 1'b0;
    res_seq             = head_seq;
    wr_en               = 1'b0;
    rd_en               = 1'b0;
    if (in_fire) begin
      case (cmd)
        CMD_PUSH: begin
          if (interrupted) begin
            res_status = ST_INTERRUPTED;
          end else if (push_diff[SEQ_W-1]) begin
            res_status = ST_STALE;
          end else if (push_diff >= SEQ_W'(DEPTH)) begin
            res_status = ST_FULL;
          end else if (slot_valid[push_slot]) begin
            res_status = ST_DUPLICATE;
          end else begin
            wr_en                      = 1'b1;
            slot_valid_next[push_slot] = 1'b1;
          end
        end
        CMD_POP: begin
          if (slot_valid[head_slot]) begin
            rd_en                      = 1'b1;
            res_pop                    = 1'b1;
            slot_valid_next[head_slot] = 1'b0;
            head_seq_next              = head_seq + SEQ_W'(1);
          end else if (producers_left == '0) begin
            res_status = ST_FINISHED;
          end else begin
            res_status = ST_EMPTY;
          end
        end
        CMD_DONE: begin
          if (producers_left != '0) begin
            producers_left_next = producers_left - CNT_W'(1);
          end
        end
        default: begin
          interrupted_next = 1'b1;
        end
      endcase
    end
    if (cfg_fire) begin
      case (cfg_index)
        CFG_FIRST_SEQ:      head_seq_next       = cfg_data;
        CFG_PRODUCER_TOTAL: producers_left_next = cfg_data[CNT_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid     <= '0;
      head_seq       <= RESET_FIRST_SEQ;
      producers_left <= RESET_PRODUCERS;
      interrupted    <= 1'b0;
      p_valid        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      slot_valid     <= slot_valid_next;
      head_seq       <= head_seq_next;
      producers_left <= producers_left_next;
      interrupted    <= interrupted_next;
      if (in_fire) begin
        p_valid <= 1'b1;
      end else if (p_move) begin
        p_valid <= 1'b0;
      end
      if (p_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_fire) begin
      p_status <= res_status;
      p_pop    <= res_pop;
      p_seq    <= res_seq;
    end
    if (p_move) begin
      status   <= p_status;
      seq_out  <= p_seq;
      data_out <= p_pop ? DATA_W'(rd_data) : '0;
    end
  end

  a_pop_is_ok: assert property (@(posedge clk) disable iff (rst)
    p_valid && p_pop |-> p_status == ST_OK)
    else $error("pop with data carries a failing status");

  a_pop_clears_slot: assert property (@(posedge clk) disable iff (rst)
    in_fire && cmd == CMD_POP && slot_valid[head_slot]
    |=> !slot_valid[$past(head_slot)])
    else $error("popped slot still marked valid");

  a_head_steady: assert property (@(posedge clk) disable iff (rst)
    !(cfg_fire && cfg_index == CFG_FIRST_SEQ) && !rd_en |=> $stable(head_seq))
    else $error("head moved without a pop or head reload");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> data_out == '0)
    else $error("nonzero data on a failed command");

endmodule

// ===== rtl/core/rob_ram.sv =====
module rob_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== tb/sv/in_order_reorder_buffer_tb.sv =====
`timescale 1ns / 1ps

module in_order_reorder_buffer_tb;
  import rob_pkg::*;

  localparam logic [DATA_W-1:0] PAYLOAD_MASK = {DATA_W{1'b1}} >> (DATA_W - PAYLOAD_BITS);

  typedef struct {
    status_t           st;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] data;
  } rob_result_t;

  class reorder_checker;
    logic [DATA_W-1:0] slot_data [DEPTH];
    bit                slot_full [DEPTH];
    logic [SEQ_W-1:0]  head_seq;
    logic [SLOT_W-1:0] head_slot;
    logic [CNT_W-1:0]  producers_left;
    bit                interrupted;
    rob_result_t       awaited [$];
    int                mismatches;

    function new();
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      head_seq       = RESET_FIRST_SEQ;
      head_slot      = RESET_FIRST_SEQ[SLOT_W-1:0];
      producers_left = RESET_PRODUCERS;
      interrupted    = 1'b0;
      mismatches     = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [SEQ_W-1:0] value);
      case (idx)
        CFG_FIRST_SEQ: begin
          head_seq  = value;
          head_slot = value[SLOT_W-1:0];
        end
        CFG_PRODUCER_TOTAL: producers_left = value[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_command(cmd_t op, logic [SEQ_W-1:0] seq, logic [DATA_W-1:0] data);
      rob_result_t       r;
      logic [SEQ_W-1:0]  diff;
      logic [SLOT_W-1:0] slot;
      r.st   = ST_OK;
      r.seq  = head_seq;
      r.data = '0;
      case (op)
        CMD_PUSH: begin
          diff = seq - head_seq;
          slot = head_slot + diff[SLOT_W-1:0];
          if (interrupted) r.st = ST_INTERRUPTED;
          else if (diff[SEQ_W-1]) r.st = ST_STALE;
          else if (diff >= SEQ_W'(DEPTH)) r.st = ST_FULL;
          else if (slot_full[slot]) r.st = ST_DUPLICATE;
          else begin
            slot_data[slot] = data & PAYLOAD_MASK;
            slot_full[slot] = 1'b1;
          end
        end
        CMD_POP: begin
          if (slot_full[head_slot]) begin
            r.data = slot_data[head_slot];
            slot_full[head_slot] = 1'b0;
            head_seq  = head_seq + 1'b1;
            head_slot = head_slot + 1'b1;
          end else begin
            r.st = (producers_left == 0) ? ST_FINISHED : ST_EMPTY;
          end
        end
        CMD_DONE: if (producers_left != 0) producers_left = producers_left - 1'b1;
        default: interrupted = 1'b1;
      endcase
      awaited.push_back(r);
    endfunction

    task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task check_result(logic [2:0] st, logic [SEQ_W-1:0] sq, logic [DATA_W-1:0] data);
      rob_result_t want;
      if (awaited.size() == 0) begin
        report("result with no transaction pending", DATA_W'(st), '0);
        return;
      end
      want = awaited.pop_front();
      if (st !== want.st) report("status", DATA_W'(st), DATA_W'(want.st));
      if (sq !== want.seq) report("seq_out", DATA_W'(sq), DATA_W'(want.seq));
      if (data !== want.data) report("data_out", data, want.data);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           cmd;
  logic [SEQ_W-1:0]     seq_in;
  logic [DATA_W-1:0]    data_in;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           status;
  logic [SEQ_W-1:0]     seq_out;
  logic [DATA_W-1:0]    data_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SEQ_W-1:0]     cfg_data;

  reorder_checker chk;
  int             sent;
  int             tx_gap_pct;
  int             rx_stall_pct;

  in_order_reorder_buffer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .seq_in    (seq_in),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .seq_out   (seq_out),
    .data_out  (data_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) chk.check_result(status, seq_out, data_out);
  end

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic idle_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic issue(cmd_t op, logic [SEQ_W-1:0] sq, logic [DATA_W-1:0] d);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
      idle_input($urandom_range(1, 13));
    in_valid <= 1'b1;
    cmd      <= op;
    seq_in   <= sq;
    data_in  <= d;
    do @(posedge clk); while (!in_ready);
    chk.note_command(op, sq, d);
    sent++;
  endtask

  task automatic push_item(logic [SEQ_W-1:0] sq);
    issue(CMD_PUSH, sq, rand_word());
  endtask

  task automatic pop_item();
    issue(CMD_POP, $urandom, rand_word());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.awaited.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SEQ_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    chk.write_register(idx, value);
  endtask

  task automatic set_registers(bit wr_seq, logic [SEQ_W-1:0] seq_val,
                               bit wr_total, logic [CNT_W-1:0] total);
    logic [SEQ_W-1:0] word;
    wait_drained();
    repeat (4) @(posedge clk);
    word = $urandom;
    word[CNT_W-1:0] = total;
    if (wr_seq) write_reg(CFG_FIRST_SEQ, seq_val);
    if (wr_total) write_reg(CFG_PRODUCER_TOTAL, word);
    cfg_valid <= 1'b0;
  endtask

  // one window of sequences pushed out of order, with stray commands mixed in
  task automatic run_batch();
    logic [SEQ_W-1:0] base;
    int               n;
    int               order [$];
    int               pick;
    base = chk.head_seq;
    n = ($urandom_range(0, 3) == 0) ? DEPTH : $urandom_range(1, DEPTH);
    for (int i = 0; i < n; i++) order.push_back(i);
    order.shuffle();
    foreach (order[i]) begin
      push_item(base + order[i]);
      pick = $urandom_range(0, 99);
      if (pick < 20) pop_item();
      else if (pick < 28) push_item(base + order[$urandom_range(0, i)]);
      else if (pick < 33) push_item($urandom);
      else if (pick < 36) push_item(chk.head_seq + DEPTH + $urandom_range(0, 3));
      else if (pick < 39) push_item(chk.head_seq - 1 - $urandom_range(0, 3));
      else if (pick < 42) issue(CMD_DONE, $urandom, rand_word());
    end
    while ($signed(base + SEQ_W'(n) - chk.head_seq) > 0) pop_item();
    if ($urandom_range(0, 3) == 0) pop_item();
  endtask

  initial begin
    out_ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if ($urandom_range(0, 99) < rx_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int goal;
    bit paused;
    chk          = new();
    sent         = 0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    cmd       <= CMD_PUSH;
    seq_in    <= '0;
    data_in   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FIRST_SEQ;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    pop_item();
    issue(CMD_PUSH, 32'd1, {DATA_W{1'b1}});
    issue(CMD_PUSH, 32'd0, '0);
    issue(CMD_PUSH, 32'd1, 64'h5555_5555_5555_5555);
    issue(CMD_PUSH, 32'd15, 64'h8000_0000_0000_0001);
    issue(CMD_PUSH, 32'd16, rand_word());
    issue(CMD_PUSH, 32'hFFFF_FFFF, rand_word());
    issue(CMD_PUSH, 32'h8000_0000, rand_word());
    issue(CMD_PUSH, 32'h7FFF_FFFF, rand_word());
    pop_item();
    pop_item();
    issue(CMD_PUSH, 32'd0, rand_word());
    pop_item();
    issue(CMD_DONE, $urandom, rand_word());
    issue(CMD_DONE, $urandom, rand_word());
    pop_item();
    issue(CMD_PUSH, 32'd2, 64'hAAAA_AAAA_AAAA_AAAA);
    pop_item();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          set_registers(1'b1, 32'hFFFF_FFF8, 1'b1, 8'd255);
          tx_gap_pct = 20; rx_stall_pct = 60;
        end
        1: begin
          set_registers(1'b1, $urandom, 1'b1, 8'd1);
          tx_gap_pct = 0; rx_stall_pct = 0;
        end
        2: begin
          set_registers(1'b1, 32'h7FFF_FFF4, 1'b0, '0);
          tx_gap_pct = 35; rx_stall_pct = 40;
        end
        3: begin
          set_registers(1'b0, '0, 1'b1, CNT_W'($urandom_range(2, 254)));
          tx_gap_pct = 10; rx_stall_pct = 90;
        end
        default: begin
          set_registers(1'b1, 32'hFFFF_FFFF, 1'b1, 8'd2);
          tx_gap_pct = 0; rx_stall_pct = 0;
        end
      endcase
      goal   = sent + 90;
      paused = 1'b0;
      while (sent < goal) begin
        run_batch();
        if (!paused && sent > goal - 45) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    // interrupt is sticky, so it only comes at the tail
    issue(CMD_INTERRUPT, $urandom, rand_word());
    push_item(chk.head_seq);
    push_item($urandom);
    issue(CMD_INTERRUPT, $urandom, rand_word());
    repeat (3) issue(CMD_DONE, $urandom, rand_word());
    repeat (24) issue(cmd_t'($urandom_range(0, 2)), $urandom, rand_word());
    repeat (DEPTH + 1) pop_item();

    wait_drained();
    repeat (10) @(posedge clk);
    if (chk.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
